// ===== rtl/core/satellite_table_upsert_lru_assert.svh =====
// ----------------------------------------------------------------------------
// Assertion macros for the satellite tracking table
// Concurrent checks that compile away when SYNTHESIS is defined.
// ----------------------------------------------------------------------------
`ifndef SATELLITE_TABLE_UPSERT_LRU_ASSERT_SVH
`define SATELLITE_TABLE_UPSERT_LRU_ASSERT_SVH

`ifndef SYNTHESIS
// Checked on every rising edge outside reset.
`define STUL_ASSERT(lbl, clk, rst_n, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
// Checked on every rising edge, reset included.
`define STUL_ASSERT_ALWAYS(lbl, clk, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);
`else
`define STUL_ASSERT(lbl, clk, rst_n, prop, msg)
`define STUL_ASSERT_ALWAYS(lbl, clk, prop, msg)
`endif

`endif

// ===== rtl/core/satl_pkg.sv =====
// ----------------------------------------------------------------------------
// Satellite table package
// Entry layout, scan control types and register constants.
// ----------------------------------------------------------------------------
package satl_pkg;

  typedef logic [23:0] key_t;
  typedef logic [23:0] info_t;
  typedef logic [31:0] ts_t;
  typedef logic [19:0] age_t;

  // One memory word: key, reported info and time stamp of the last write.
  typedef struct packed {
    key_t  key;
    info_t info;
    ts_t   ts;
  } entry_t;

  typedef struct packed {
    logic clear;
    logic eval;
    logic prune;
  } scan_ctl_t;

  typedef struct packed {
    logic match_found;
    logic free_found;
    logic old_found;
  } scan_res_t;

  localparam logic FUNC_UPSERT = 1'b0;
  localparam logic FUNC_PRUNE  = 1'b1;

  localparam logic REG_STALE_AGE = 1'b0;

  localparam age_t STALE_AGE_RESET = 20'd6000;

endpackage

// ===== rtl/core/satl_mem.sv =====
// ----------------------------------------------------------------------------
// Satellite table entry memory
// One write port and one registered read port.
// ----------------------------------------------------------------------------
module satl_mem #(
  parameter int DEPTH = 32,
  parameter int AW    = 5
) (
  input  logic             clk,
  input  logic             wr_en,
  input  logic [AW-1:0]    wr_addr,
  input  satl_pkg::entry_t wr_data,
  input  logic             rd_en,
  input  logic [AW-1:0]    rd_addr,
  output satl_pkg::entry_t rd_data
);
  import satl_pkg::*;

  entry_t mem_r [DEPTH];
  entry_t rd_data_r;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem_r[wr_addr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data_r <= mem_r[rd_addr];
    end
  end

  assign rd_data = rd_data_r;

endmodule

// ===== rtl/core/satl_scan.sv =====
// ----------------------------------------------------------------------------
// Satellite table scan unit
// Looks at one entry per cycle while eval is high: when not pruning it tracks
// the first match, first free slot and oldest valid entry; it flags stale ones.
// ----------------------------------------------------------------------------
module satl_scan #(
  parameter int AW = 5
) (
  input  logic                clk,
  input  logic                rst_n,
  input  satl_pkg::scan_ctl_t ctl,
  input  logic [AW-1:0]       idx,
  input  logic                entry_vld,
  input  satl_pkg::entry_t    entry,
  input  satl_pkg::key_t      key,
  input  satl_pkg::ts_t       now,
  input  satl_pkg::age_t      stale_age,
  output logic                stale,
  output satl_pkg::scan_res_t res,
  output logic [AW-1:0]       match_idx,
  output logic [AW-1:0]       free_idx,
  output logic [AW-1:0]       old_idx
);
  import satl_pkg::*;

  scan_res_t     res_r;
  logic [AW-1:0] match_idx_r;
  logic [AW-1:0] free_idx_r;
  logic [AW-1:0] old_idx_r;
  ts_t           old_ts_r;
  ts_t           age;

  // Age wraps modulo 2^32, so a plain subtraction is enough.
  assign age   = now - entry.ts;
  assign stale = entry_vld && (age > 32'(stale_age));

  always_ff @(posedge clk) begin
    if (!rst_n || ctl.clear) begin
      res_r <= '0;
    end else if (ctl.eval && !ctl.prune) begin
      if (entry_vld) begin
        if (!res_r.match_found && entry.key == key) begin
          res_r.match_found <= 1'b1;
        end
        if (!res_r.old_found || entry.ts < old_ts_r) begin
          res_r.old_found <= 1'b1;
        end
      end else if (!res_r.free_found) begin
        res_r.free_found <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.eval && !ctl.prune) begin
      if (entry_vld) begin
        if (!res_r.match_found && entry.key == key) begin
          match_idx_r <= idx;
        end
        // Strict compare keeps the lowest index on a tie.
        if (!res_r.old_found || entry.ts < old_ts_r) begin
          old_idx_r <= idx;
          old_ts_r  <= entry.ts;
        end
      end else if (!res_r.free_found) begin
        free_idx_r <= idx;
      end
    end
  end

  assign res       = res_r;
  assign match_idx = match_idx_r;
  assign free_idx  = free_idx_r;
  assign old_idx   = old_idx_r;

endmodule

// ===== rtl/core/satellite_table_upsert_lru.sv =====
// ----------------------------------------------------------------------------
// Satellite tracking table with LRU replacement and aging
// Associative table keyed by talker code and PRN, held in one memory.
// ----------------------------------------------------------------------------
// Usage:
// A request is taken at a rising edge with start high and busy low. in_func
// selects an upsert (refresh or insert one satellite) or a prune (drop every
// entry older than the stale limit). Each request gives one result, shown on
// the out_ ports for one cycle with out_valid high; the receiver takes it then.
// Operation: the table is swept through its single read port, one entry per
// cycle, followed by a drain state to finish the last compare and a write
// state. busy stays high through the scan, drain and write states;
// out_valid rises in the cycle busy falls, and a new request may be started
// in that same cycle. A request is only taken once the previous one has
// finished, and the write back and the next sweep never overlap, so no
// forwarding is needed.
// Configuration: one register, stale_age_ms, at byte address 0 of the APB
// port; write it only while busy is low.
// Reset (rst_n low, synchronous) empties the table and sets the stale limit
// to 6000 ms. No clearing pass is needed: valid bits are held in flip-flops.
// ----------------------------------------------------------------------------
`include "satellite_table_upsert_lru_assert.svh"

module satellite_table_upsert_lru #(
  parameter int TABLE_DEPTH = 32
) (
  input  logic        clk,
  input  logic        rst_n,
  // request channel
  input  logic        start,
  output logic        busy,
  input  logic        in_func,
  input  logic [31:0] in_now_ms,
  input  logic [15:0] in_talker_code,
  input  logic [7:0]  in_prn,
  input  logic [6:0]  in_elevation,
  input  logic [8:0]  in_azimuth,
  input  logic signed [7:0] in_snr,
  // result channel
  output logic        out_valid,
  output logic [4:0]  out_slot_used,
  output logic        out_hit,
  output logic        out_evicted,
  output logic [5:0]  out_valid_count,
  output logic [5:0]  out_removed_count,
  // configuration
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);
  import satl_pkg::*;

  localparam int AW = $clog2(TABLE_DEPTH);
  localparam int CW = $clog2(TABLE_DEPTH + 1);
  localparam int SW = (AW > 5) ? AW : 5;
  localparam int OW = (CW > 6) ? CW : 6;

  typedef enum logic [3:0] {
    S_IDLE  = 4'b0001,
    S_SCAN  = 4'b0010,
    S_DRAIN = 4'b0100,
    S_WRITE = 4'b1000
  } state_t;

  state_t           state_r, state_nxt;
  logic             accept;
  logic [AW-1:0]    cnt_r;
  logic             eval_vld_r;
  logic [AW-1:0]    eval_idx_r;
  logic [TABLE_DEPTH-1:0] vld_r;
  logic [CW-1:0]    vcount_r;
  logic [CW-1:0]    removed_r;
  age_t             stale_age_r;

  logic             func_r;
  ts_t              now_r;
  key_t             key_r;
  info_t            info_r;

  entry_t           rd_data;
  entry_t           wr_data;
  logic             wr_en;
  logic [AW-1:0]    target;
  logic             stale;
  logic             remove;
  scan_ctl_t        scan_ctl;
  scan_res_t        scan_res;
  logic [AW-1:0]    match_idx;
  logic [AW-1:0]    free_idx;
  logic [AW-1:0]    old_idx;
  logic             cfg_wr;
  logic             reg_idx;
  logic [SW-1:0]    slot_ext;
  logic [OW-1:0]    vcount_ext;
  logic [OW-1:0]    removed_ext;
  logic [CW-1:0]    vcount_nxt;

  assign accept = start && !busy;
  assign busy   = (state_r != S_IDLE);

  // ---------------------------------------------------------------- control
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      S_IDLE:  if (accept) state_nxt = S_SCAN;
      S_SCAN:  if (cnt_r == AW'(TABLE_DEPTH - 1)) state_nxt = S_DRAIN;
      S_DRAIN: state_nxt = S_WRITE;
      S_WRITE: state_nxt = S_IDLE;
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r    <= S_IDLE;
      cnt_r      <= '0;
      eval_vld_r <= 1'b0;
    end else begin
      state_r    <= state_nxt;
      eval_vld_r <= (state_r == S_SCAN);
      if (accept) begin
        cnt_r <= '0;
      end else if (state_r == S_SCAN) begin
        cnt_r <= cnt_r + 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    eval_idx_r <= cnt_r;
    if (accept) begin
      func_r <= in_func;
      now_r  <= in_now_ms;
      key_r  <= {in_talker_code, in_prn};
      info_r <= {in_elevation, in_azimuth, in_snr};
    end
  end

  // ----------------------------------------------------------------- memory
  assign wr_en   = (state_r == S_WRITE) && (func_r == FUNC_UPSERT);
  assign wr_data = '{key: key_r, info: info_r, ts: now_r};

  satl_mem #(
    .DEPTH (TABLE_DEPTH),
    .AW    (AW)
  ) u_mem (
    .clk     (clk),
    .wr_en   (wr_en),
    .wr_addr (target),
    .wr_data (wr_data),
    .rd_en   (state_r == S_SCAN),
    .rd_addr (cnt_r),
    .rd_data (rd_data)
  );

  // ------------------------------------------------------------------- scan
  assign scan_ctl = '{clear: accept, eval: eval_vld_r, prune: (func_r == FUNC_PRUNE)};

  satl_scan #(
    .AW (AW)
  ) u_scan (
    .clk       (clk),
    .rst_n     (rst_n),
    .ctl       (scan_ctl),
    .idx       (eval_idx_r),
    .entry_vld (vld_r[eval_idx_r]),
    .entry     (rd_data),
    .key       (key_r),
    .now       (now_r),
    .stale_age (stale_age_r),
    .stale     (stale),
    .res       (scan_res),
    .match_idx (match_idx),
    .free_idx  (free_idx),
    .old_idx   (old_idx)
  );

  assign remove = eval_vld_r && (func_r == FUNC_PRUNE) && stale;

  always_comb begin
    if (scan_res.match_found) begin
      target = match_idx;
    end else if (scan_res.free_found) begin
      target = free_idx;
    end else if (scan_res.old_found) begin
      target = old_idx;
    end else begin
      target = '0;
    end
  end

  // A new entry only grows the count when it lands in a free slot.
  always_comb begin
    vcount_nxt = vcount_r;
    if (remove) begin
      vcount_nxt = vcount_r - 1'b1;
    end else if (wr_en && !scan_res.match_found && scan_res.free_found) begin
      vcount_nxt = vcount_r + 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r     <= '0;
      vcount_r  <= '0;
      removed_r <= '0;
    end else begin
      vcount_r <= vcount_nxt;
      if (remove) begin
        vld_r[eval_idx_r] <= 1'b0;
      end else if (wr_en) begin
        vld_r[target] <= 1'b1;
      end
      if (accept) begin
        removed_r <= '0;
      end else if (remove) begin
        removed_r <= removed_r + 1'b1;
      end
    end
  end

  // ----------------------------------------------------------------- result
  assign slot_ext    = SW'(target);
  assign vcount_ext  = OW'(vcount_nxt);
  assign removed_ext = OW'(removed_r);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid <= 1'b0;
    end else begin
      out_valid <= (state_r == S_WRITE);
    end
  end

  always_ff @(posedge clk) begin
    if (state_r == S_WRITE) begin
      out_valid_count <= vcount_ext[5:0];
      if (func_r == FUNC_UPSERT) begin
        out_slot_used     <= slot_ext[4:0];
        out_hit           <= scan_res.match_found;
        out_evicted       <= !scan_res.match_found && !scan_res.free_found;
        out_removed_count <= '0;
      end else begin
        out_slot_used     <= '0;
        out_hit           <= 1'b0;
        out_evicted       <= 1'b0;
        out_removed_count <= removed_ext[5:0];
      end
    end
  end

  // ---------------------------------------------------------- configuration
  assign pready  = 1'b1;
  assign reg_idx = paddr[2];
  assign cfg_wr  = psel && penable && pwrite && pready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      stale_age_r <= STALE_AGE_RESET;
    end else if (cfg_wr && reg_idx == REG_STALE_AGE) begin
      stale_age_r <= pwdata[19:0];
    end
  end

  always_comb begin
    unique case (reg_idx)
      REG_STALE_AGE: prdata = 32'(stale_age_r);
      default:       prdata = '0;
    endcase
  end

  // ------------------------------------------------------------- assertions
  `STUL_ASSERT(a_count_matches_valid, clk, rst_n,
    vcount_r == CW'($countones(vld_r)), "valid count out of step with valid bits")
  `STUL_ASSERT(a_accept_starts_scan, clk, rst_n,
    accept |=> (state_r == S_SCAN && cnt_r == '0), "accepted request did not start a sweep")
  `STUL_ASSERT(a_result_when_idle, clk, rst_n,
    out_valid |-> (!busy && $past(state_r) == S_WRITE), "result outside the write back")
  `STUL_ASSERT(a_hit_not_evict, clk, rst_n,
    out_valid |-> !(out_hit && out_evicted), "result flags both hit and eviction")
  `STUL_ASSERT(a_no_write_in_scan, clk, rst_n,
    (state_r == S_SCAN || state_r == S_DRAIN) |-> !wr_en, "memory written during a sweep")

endmodule
